### rtl/srvp_pkg.sv
package srvp_pkg;

  localparam int unsigned US_W       = 12;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned TICK_W     = 12;
  localparam int unsigned ECHO_W     = 13;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam int unsigned US_FLOOR       = 500;
  localparam int unsigned US_CEIL        = 2500;
  localparam int unsigned POS_TOP        = 100;
  localparam int unsigned POS_BOTTOM_MAG = 100;

  localparam int unsigned NECK_MIN_RST     = 1000;
  localparam int unsigned NECK_NEUTRAL_RST = 1450;
  localparam int unsigned NECK_MAX_RST     = 2000;
  localparam int unsigned JAW_MIN_RST      = 1000;
  localparam int unsigned JAW_NEUTRAL_RST  = 1600;
  localparam int unsigned JAW_MAX_RST      = 1600;

  localparam int unsigned TICK_MAX = (1 << TICK_W) - 1;

  // product of width difference magnitude and position magnitude
  localparam int unsigned PROD_W = US_W + POS_W;
  // reciprocal divide, exact for any PROD_W-bit numerator and divisor up to 2**POS_W
  localparam int unsigned REC_S  = PROD_W + POS_W;
  localparam int unsigned REC_W  = REC_S + 1;
  localparam int unsigned MUL_W  = PROD_W + REC_W;
  localparam longint unsigned REC_TOP =
    ((64'd1 << REC_S) + POS_TOP - 1) / POS_TOP;
  localparam longint unsigned REC_BOT =
    ((64'd1 << REC_S) + POS_BOTTOM_MAG - 1) / POS_BOTTOM_MAG;

  localparam logic [1:0] CAL_MIN     = 2'd0;
  localparam logic [1:0] CAL_NEUTRAL = 2'd1;
  localparam logic [1:0] CAL_MAX     = 2'd2;

  typedef enum logic [1:0] {
    FUNC_POS   = 2'd0,
    FUNC_PULSE = 2'd1,
    FUNC_GATE  = 2'd2
  } srvp_func_t;

  typedef struct packed {
    logic [US_W-1:0] min_us;
    logic [US_W-1:0] center_us;
    logic [US_W-1:0] max_us;
    logic            invert;
  } srvp_cal_t;

  typedef struct packed {
    srvp_func_t              func;
    logic                    servo_sel;
    logic signed [POS_W-1:0] position;
    logic [PULSE_W-1:0]      pulse_us;
    logic                    gate_on;
  } srvp_cmd_t;

  typedef struct packed {
    srvp_func_t              func;
    logic                    ch;
    logic                    gate_on;
    logic signed [POS_W-1:0] pos;
    logic [US_W-1:0]         req_us;
    logic [US_W-1:0]         center_us;
    logic [PROD_W-1:0]       prod;
    logic                    neg;
    logic                    bot;
  } srvp_prod_t;

  typedef struct packed {
    logic                     channel;
    logic                     duty_write;
    logic [TICK_W-1:0]        duty_ticks;
    logic signed [ECHO_W-1:0] echo_value;
    logic                     gate_state;
    logic                     last;
  } srvp_result_t;

  function automatic logic [US_W-1:0] rail_us(input logic [PULSE_W-1:0] v);
    logic [US_W-1:0] r;
    if (v < PULSE_W'(US_FLOOR)) begin
      r = US_W'(US_FLOOR);
    end else if (v > PULSE_W'(US_CEIL)) begin
      r = US_W'(US_CEIL);
    end else begin
      r = v[US_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/srvp_cal_regs.sv
module srvp_cal_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [srvp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [srvp_pkg::US_W-1:0]           cfg_wdata,
  output srvp_pkg::srvp_cal_t [1:0]           cal
);
  import srvp_pkg::*;

  srvp_cal_t [1:0] cal_r;
  srvp_cal_t [1:0] cal_nxt;
  logic [US_W-1:0] railed;

  assign railed = rail_us(PULSE_W'(cfg_wdata));

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      case (cfg_addr[1:0])
        CAL_MIN:     cal_nxt[cfg_addr[2]].min_us    = railed;
        CAL_NEUTRAL: cal_nxt[cfg_addr[2]].center_us = railed;
        CAL_MAX:     cal_nxt[cfg_addr[2]].max_us    = railed;
        // invert flag
        default:     cal_nxt[cfg_addr[2]].invert    = cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r[0].min_us    <= US_W'(NECK_MIN_RST);
      cal_r[0].center_us <= US_W'(NECK_NEUTRAL_RST);
      cal_r[0].max_us    <= US_W'(NECK_MAX_RST);
      cal_r[0].invert    <= 1'b1;
      cal_r[1].min_us    <= US_W'(JAW_MIN_RST);
      cal_r[1].center_us <= US_W'(JAW_NEUTRAL_RST);
      cal_r[1].max_us    <= US_W'(JAW_MAX_RST);
      cal_r[1].invert    <= 1'b0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule

### rtl/srvp_map.sv
module srvp_map (
  input  logic                      clk,
  input  logic                      load,
  input  srvp_pkg::srvp_cmd_t       cmd,
  input  srvp_pkg::srvp_cal_t [1:0] cal,
  output srvp_pkg::srvp_prod_t      prod
);
  import srvp_pkg::*;

  srvp_prod_t            prod_r;
  srvp_prod_t            prod_nxt;
  srvp_cal_t             c;
  logic signed [POS_W:0] pos_ext;
  logic signed [POS_W:0] pos_clamp;
  logic signed [POS_W:0] m;
  logic                  m_neg;
  logic [POS_W-1:0]      k;
  logic signed [US_W:0]  d;
  logic [US_W-1:0]       d_mag;

  assign c       = cal[cmd.servo_sel];
  assign pos_ext = {cmd.position[POS_W-1], cmd.position};

  always_comb begin
    if (pos_ext > $signed((POS_W+1)'(POS_TOP))) begin
      pos_clamp = $signed((POS_W+1)'(POS_TOP));
    end else if (pos_ext < -$signed((POS_W+1)'(POS_BOTTOM_MAG))) begin
      pos_clamp = -$signed((POS_W+1)'(POS_BOTTOM_MAG));
    end else begin
      pos_clamp = pos_ext;
    end
    m     = c.invert ? -pos_clamp : pos_clamp;
    m_neg = m[POS_W];
    k     = m_neg ? POS_W'(-m) : POS_W'(m);
    d     = m_neg ? $signed({1'b0, c.center_us}) - $signed({1'b0, c.min_us})
                  : $signed({1'b0, c.max_us}) - $signed({1'b0, c.center_us});
    d_mag = d[US_W] ? US_W'(-d) : US_W'(d);

    prod_nxt.func      = cmd.func;
    prod_nxt.ch        = cmd.servo_sel;
    prod_nxt.gate_on   = cmd.gate_on;
    prod_nxt.pos       = pos_clamp[POS_W-1:0];
    prod_nxt.req_us    = rail_us(cmd.pulse_us);
    prod_nxt.center_us = c.center_us;
    prod_nxt.prod      = PROD_W'(d_mag) * PROD_W'(k);
    // sign of the offset from neutral
    prod_nxt.neg       = m_neg ? (c.min_us < c.center_us) : (c.max_us < c.center_us);
    prod_nxt.bot       = m_neg;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

### rtl/srvp_exec.sv
module srvp_exec (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s2_valid,
  input  srvp_pkg::srvp_prod_t      prod,
  input  srvp_pkg::srvp_cal_t [1:0] cal,
  input  logic                      out_ready,
  output logic                      s2_done,
  output logic                      out_valid,
  output srvp_pkg::srvp_result_t    out_res
);
  import srvp_pkg::*;

  localparam int unsigned SUM_W = PROD_W + 2;

  logic [US_W-1:0]         pulse_r [2];
  logic                    gate_r;
  logic                    gate_nxt;
  logic                    phase_r;
  logic                    phase_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  srvp_result_t            out_res_r;
  srvp_result_t            res;

  logic [REC_W-1:0]        rec;
  logic [MUL_W-1:0]        q_full;
  logic [PROD_W-1:0]       q;
  logic signed [SUM_W-1:0] us_sum;
  logic [US_W-1:0]         us_map;
  logic [US_W-1:0]         res_us;
  logic                    emit;
  logic                    store;
  logic                    is_gate;
  logic                    out_free;
  logic                    fire;

  function automatic logic [TICK_W-1:0] ticks_of(input logic [US_W-1:0] us);
    logic [US_W+1:0] t3;
    logic [US_W:0]   t;
    t3 = {2'b00, us} + {1'b0, us, 1'b0};
    t  = t3[US_W+1:1];
    return (t > (US_W+1)'(TICK_MAX)) ? TICK_W'(TICK_MAX) : t[TICK_W-1:0];
  endfunction

  assign rec    = prod.bot ? REC_W'(REC_BOT) : REC_W'(REC_TOP);
  assign q_full = MUL_W'(prod.prod) * MUL_W'(rec);
  assign q      = q_full[REC_S +: PROD_W];
  assign us_sum = prod.neg ? $signed(SUM_W'(prod.center_us)) - $signed(SUM_W'(q))
                           : $signed(SUM_W'(prod.center_us)) + $signed(SUM_W'(q));

  always_comb begin
    if (us_sum < $signed(SUM_W'(US_FLOOR))) begin
      us_map = US_W'(US_FLOOR);
    end else if (us_sum > $signed(SUM_W'(US_CEIL))) begin
      us_map = US_W'(US_CEIL);
    end else begin
      us_map = us_sum[US_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    emit    = 1'b0;
    store   = 1'b0;
    is_gate = 1'b0;
    res_us  = prod.req_us;
    res.channel    = prod.ch;
    res.duty_write = gate_r;
    res.echo_value = ECHO_W'($unsigned(prod.req_us));
    res.gate_state = gate_r;
    res.last       = 1'b1;
    case (prod.func)
      FUNC_POS: begin
        emit           = 1'b1;
        store          = 1'b1;
        res_us         = us_map;
        res.echo_value = ECHO_W'(prod.pos);
      end
      FUNC_PULSE: begin
        emit  = 1'b1;
        store = 1'b1;
      end
      FUNC_GATE: begin
        is_gate        = 1'b1;
        emit           = phase_r || (prod.gate_on != gate_r);
        res_us         = prod.gate_on ? pulse_r[phase_r] : cal[phase_r].center_us;
        res.channel    = phase_r;
        res.duty_write = 1'b1;
        res.echo_value = ECHO_W'(res_us);
        res.gate_state = prod.gate_on;
        res.last       = phase_r;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    res.duty_ticks = ticks_of(res_us);
  end

  assign fire    = s2_valid && emit && out_free;
  assign s2_done = s2_valid && (!emit || (out_free && (!is_gate || phase_r)));

  always_comb begin
    gate_nxt      = gate_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (fire) begin
      out_valid_nxt = 1'b1;
      if (is_gate) begin
        gate_nxt  = prod.gate_on;
        phase_nxt = !phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r[0]  <= US_W'(NECK_NEUTRAL_RST);
      pulse_r[1]  <= US_W'(JAW_NEUTRAL_RST);
      gate_r      <= 1'b1;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      gate_r      <= gate_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire && store) begin
        pulse_r[prod.ch] <= res_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### rtl/servo_position_to_pulse_mapper.sv
// a command passes the command register, the mapping register and the result register
// before out_tvalid rises, and a stall can hold it in any of them
// throughput: one command per cycle when not stalled; a gate change holds the execute
// stage for its two results, and backpressure stalls the pipeline at the result register
// reset (synchronous, rst_n low): pipeline emptied, calibration to defaults,
// gate open, stored pulse widths back to each channel's default neutral
module servo_position_to_pulse_mapper (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // position[7:0], pulse_us[23:8], gate_on[24], zero fill
  input  logic [31:0]                     in_tdata,
  // func[1:0], servo_sel[2]
  input  logic [2:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // duty_write[0], duty_ticks[12:1], echo_value[25:13], gate_state[26], zero fill
  output logic [31:0]                     out_tdata,
  // channel
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [srvp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [srvp_pkg::US_W-1:0]       cfg_wdata
);
  import srvp_pkg::*;

  srvp_cal_t [1:0] cal;
  srvp_cmd_t       cmd_r;
  srvp_cmd_t       cmd_nxt;
  srvp_prod_t      prod;
  srvp_result_t    res;
  logic            s1_valid_r;
  logic            s1_valid_nxt;
  logic            s2_valid_r;
  logic            s2_valid_nxt;
  logic            s2_done;
  logic            s2_free;
  logic            s1_adv;
  logic            in_xfer;

  assign cmd_nxt.func      = srvp_func_t'(in_tuser[1:0]);
  assign cmd_nxt.servo_sel = in_tuser[2];
  assign cmd_nxt.position  = in_tdata[POS_W-1:0];
  assign cmd_nxt.pulse_us  = in_tdata[POS_W +: PULSE_W];
  assign cmd_nxt.gate_on   = in_tdata[POS_W+PULSE_W];

  assign s2_free      = !s2_valid_r || s2_done;
  assign s1_adv       = s1_valid_r && s2_free;
  assign in_tready    = !s1_valid_r || s2_free;
  assign in_xfer      = in_tvalid && in_tready;
  assign s1_valid_nxt = in_xfer || (s1_valid_r && !s2_free);
  assign s2_valid_nxt = s1_adv || (s2_valid_r && !s2_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= cmd_nxt;
    end
  end

  srvp_cal_regs u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cal       (cal)
  );

  srvp_map u_map (
    .clk  (clk),
    .load (s1_adv),
    .cmd  (cmd_r),
    .cal  (cal),
    .prod (prod)
  );

  srvp_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid_r),
    .prod      (prod),
    .cal       (cal),
    .out_ready (out_tready),
    .s2_done   (s2_done),
    .out_valid (out_tvalid),
    .out_res   (res)
  );

  assign out_tdata = {5'b0, res.gate_state, res.echo_value, res.duty_ticks, res.duty_write};
  assign out_tuser = res.channel;
  assign out_tlast = res.last;

endmodule
